// ===== src/fcd_pkg.sv =====
package fcd_pkg;

	localparam int MAX_PIXELS_DEF = 65536;

	localparam int PIX_W   = 8;
	localparam int SIDE_W  = 9;
	localparam int THR_W   = 8;
	localparam int PCT_W   = 7;
	localparam int AREA_W  = 17;
	localparam int COUNT_W = 17;
	localparam int FRAME_W = 24;
	localparam int PROD_W  = 24;

	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	localparam int OUT_DEPTH = 4;
	localparam int LEVEL_W   = $clog2(OUT_DEPTH + 1);
	localparam int PTR_W     = $clog2(OUT_DEPTH);

	localparam logic [SIDE_W-1:0] SIDE_MAX      = 9'd256;
	localparam logic [SIDE_W-1:0] ROI_WIDTH_RST = 9'd256;
	localparam logic [SIDE_W-1:0] ROI_HEIGHT_RST = 9'd256;
	localparam logic [THR_W-1:0]  THRESHOLD_RST = 8'd30;
	localparam logic [PCT_W-1:0]  PERCENT_RST   = 7'd1;

	typedef enum logic [1:0] {
		REG_ROI_WIDTH,
		REG_ROI_HEIGHT,
		REG_DIFF_THRESHOLD,
		REG_MIN_CHANGED_PERCENT
	} reg_idx_t;

	typedef struct packed {
		logic [AREA_W-1:0] area;
		logic [THR_W-1:0]  diff_threshold;
		logic [PROD_W-1:0] pct_area;
	} cfg_t;

	typedef struct packed {
		logic               frame_changed;
		logic [COUNT_W-1:0] changed_pixels;
		logic [FRAME_W-1:0] frame_index;
	} result_t;

endpackage

// ===== src/fcd_pixel_if.sv =====
interface fcd_pixel_if import fcd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] blue;
	logic [PIX_W-1:0] green;
	logic [PIX_W-1:0] red;

	modport source (output valid, output blue, output green, output red, input ready);
	modport sink (input valid, input blue, input green, input red, output ready);
endinterface

// ===== src/fcd_result_if.sv =====
interface fcd_result_if import fcd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               frame_changed;
	logic [COUNT_W-1:0] changed_pixels;
	logic [FRAME_W-1:0] frame_index;

	modport source (output valid, output frame_changed, output changed_pixels,
		output frame_index, input ready);
	modport sink (input valid, input frame_changed, input changed_pixels,
		input frame_index, output ready);
endinterface

// ===== src/fcd_ram.sv =====
module fcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic [AW-1:0]        raddr,
	output logic [WIDTH-1:0]     rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== src/fcd_cfg.sv =====
module fcd_cfg import fcd_pkg::*; #(
	parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);
	localparam logic [20:0] MAXP = 21'(MAX_PIXELS);

	logic [SIDE_W-1:0] roi_width_q;
	logic [SIDE_W-1:0] roi_height_q;
	logic [THR_W-1:0]  diff_threshold_q;
	logic [PCT_W-1:0]  min_changed_percent_q;
	logic [PROD_W-1:0] pct_area_q;

	logic              wr;
	reg_idx_t          idx;
	logic [SIDE_W-1:0] w_c;
	logic [SIDE_W-1:0] h_c;
	logic [17:0]       prod;
	logic [AREA_W-1:0] area;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roi_width_q <= ROI_WIDTH_RST;
			roi_height_q <= ROI_HEIGHT_RST;
			diff_threshold_q <= THRESHOLD_RST;
			min_changed_percent_q <= PERCENT_RST;
		end else if (wr) begin
			unique case (idx)
				REG_ROI_WIDTH: begin
					roi_width_q <= pwdata[SIDE_W-1:0];
				end
				REG_ROI_HEIGHT: begin
					roi_height_q <= pwdata[SIDE_W-1:0];
				end
				REG_DIFF_THRESHOLD: begin
					diff_threshold_q <= pwdata[THR_W-1:0];
				end
				REG_MIN_CHANGED_PERCENT: begin
					min_changed_percent_q <= pwdata[PCT_W-1:0];
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_ROI_WIDTH:           prdata = APB_DW'(roi_width_q);
			REG_ROI_HEIGHT:          prdata = APB_DW'(roi_height_q);
			REG_DIFF_THRESHOLD:      prdata = APB_DW'(diff_threshold_q);
			REG_MIN_CHANGED_PERCENT: prdata = APB_DW'(min_changed_percent_q);
		endcase
	end

	// sides clamp to 1..256, area saturates at the buffer size
	always_comb begin
		w_c = (roi_width_q == '0) ? SIDE_W'(1) :
			(roi_width_q > SIDE_MAX) ? SIDE_MAX : roi_width_q;
		h_c = (roi_height_q == '0) ? SIDE_W'(1) :
			(roi_height_q > SIDE_MAX) ? SIDE_MAX : roi_height_q;
		prod = 18'(w_c) * 18'(h_c);
		area = (21'(prod) > MAXP) ? MAXP[AREA_W-1:0] : prod[AREA_W-1:0];
	end

	always_ff @(posedge clk) begin
		pct_area_q <= PROD_W'(min_changed_percent_q) * PROD_W'(area);
	end

	assign cfg.area = area;
	assign cfg.diff_threshold = diff_threshold_q;
	assign cfg.pct_area = pct_area_q;

	a_area_range: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.area != '0 && 21'(cfg.area) <= MAXP)
		else $error("area out of range");
endmodule

// ===== src/fcd_pipe.sv =====
module fcd_pipe import fcd_pkg::*; #(
	parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	fcd_pixel_if.sink          pixel,
	input  cfg_t               cfg,
	input  logic [LEVEL_W-1:0] out_level,
	output logic               res_push,
	output result_t            res
);
	localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int CW = (AW > AREA_W) ? AW : AREA_W;
	localparam logic [LEVEL_W:0] READY_LIM = (LEVEL_W + 1)'(OUT_DEPTH - 1);
	localparam logic [13:0] W_BLUE  = 14'd1868;
	localparam logic [13:0] W_GREEN = 14'd9617;
	localparam logic [13:0] W_RED   = 14'd4899;
	localparam logic [23:0] GRAY_RND = 24'd8192;
	localparam int GRAY_SHIFT = 14;
	localparam logic [PROD_W-1:0] PERCENT_SCALE = 24'd100;

	// control state
	logic [AW-1:0]      pixel_position_q;
	logic [COUNT_W-1:0] changed_count_q;
	logic [FRAME_W-1:0] frame_counter_q;
	logic               ref_sel_q;
	logic               have_ref_q;

	// stage 1
	logic               valid_s1;
	logic               last_s1;
	logic [AW-1:0]      pos_s1;
	logic [PIX_W-1:0]   blue_s1;
	logic [PIX_W-1:0]   green_s1;
	logic [PIX_W-1:0]   red_s1;
	logic [1:0]         fwd_hit_s1;
	logic [PIX_W-1:0]   fwd_data_s1 [2];

	// stage 2
	logic               valid_s2;
	logic               last_s2;
	logic [AW-1:0]      pos_s2;
	logic [PIX_W-1:0]   gray_s2;
	logic [1:0]         fwd_hit_s2;
	logic [PIX_W-1:0]   fwd_data_s2 [2];
	logic [PIX_W-1:0]   ram_data_s2 [2];

	logic               acc;
	logic [CW-1:0]      pos_ext;
	logic [CW-1:0]      last_pos;
	logic [CW-1:0]      pos_cl;
	logic [AW-1:0]      pos0;
	logic               last0;
	logic [LEVEL_W:0]   pending;
	logic [23:0]        gray_sum;
	logic [PIX_W-1:0]   gray_s1c;
	logic [1:0]         we;
	logic [1:0]         hit0;
	logic [1:0]         hit1;
	logic [PIX_W-1:0]   rd_data [2];
	logic [PIX_W-1:0]   refv;
	logic [PIX_W-1:0]   diff;
	logic               inc;
	logic [COUNT_W-1:0] count_sum;
	logic               changed;

	// stage 0: position, ready and bank reads
	assign pending = (LEVEL_W + 1)'(valid_s1 && last_s1) + (LEVEL_W + 1)'(valid_s2 && last_s2);
	assign pixel.ready = ((LEVEL_W + 1)'(out_level) + pending) <= READY_LIM;
	assign acc = pixel.valid && pixel.ready;

	always_comb begin
		pos_ext = CW'(pixel_position_q);
		last_pos = CW'(cfg.area) - CW'(1);
		pos_cl = (pos_ext > last_pos) ? last_pos : pos_ext;
		pos0 = pos_cl[AW-1:0];
		last0 = (pos_cl == last_pos);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_position_q <= '0;
		end else if (acc) begin
			pixel_position_q <= last0 ? '0 : pos0 + AW'(1);
		end
	end

	// writes happen in stage 2 into the bank that is not the reference
	assign we[0] = valid_s2 && ref_sel_q;
	assign we[1] = valid_s2 && !ref_sel_q;

	for (genvar k = 0; k < 2; k++) begin : g_bank
		fcd_ram #(
			.WIDTH(PIX_W),
			.DEPTH(MAX_PIXELS)
		) u_ram (
			.clk  (clk),
			.we   (we[k]),
			.waddr(pos_s2),
			.wdata(gray_s2),
			.raddr(pos0),
			.rdata(rd_data[k])
		);

		// forward writes that land after the read was issued
		assign hit0[k] = we[k] && (pos_s2 == pos0);
		assign hit1[k] = we[k] && (pos_s2 == pos_s1);

		always_ff @(posedge clk) begin
			fwd_hit_s1[k] <= hit0[k];
			fwd_data_s1[k] <= gray_s2;
			fwd_hit_s2[k] <= hit1[k] || fwd_hit_s1[k];
			fwd_data_s2[k] <= hit1[k] ? gray_s2 : fwd_data_s1[k];
			ram_data_s2[k] <= rd_data[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= acc;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		last_s1 <= last0;
		pos_s1 <= pos0;
		blue_s1 <= pixel.blue;
		green_s1 <= pixel.green;
		red_s1 <= pixel.red;
		last_s2 <= last_s1;
		pos_s2 <= pos_s1;
		gray_s2 <= gray_s1c;
	end

	// stage 1: gray conversion
	always_comb begin
		gray_sum = 24'(blue_s1) * 24'(W_BLUE) + 24'(green_s1) * 24'(W_GREEN)
			+ 24'(red_s1) * 24'(W_RED) + GRAY_RND;
		gray_s1c = gray_sum[GRAY_SHIFT +: PIX_W];
	end

	// stage 2: compare, count, frame decision
	always_comb begin
		refv = fwd_hit_s2[ref_sel_q] ? fwd_data_s2[ref_sel_q] : ram_data_s2[ref_sel_q];
		diff = (gray_s2 >= refv) ? gray_s2 - refv : refv - gray_s2;
		inc = have_ref_q && (diff > cfg.diff_threshold);
		count_sum = changed_count_q + COUNT_W'(inc);
		changed = !have_ref_q || (PROD_W'(count_sum) * PERCENT_SCALE >= cfg.pct_area);
	end

	assign res_push = valid_s2 && last_s2;
	assign res.frame_changed = changed;
	assign res.changed_pixels = count_sum;
	assign res.frame_index = frame_counter_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			changed_count_q <= '0;
			frame_counter_q <= '0;
			ref_sel_q <= 1'b0;
			have_ref_q <= 1'b0;
		end else if (res_push) begin
			changed_count_q <= '0;
			frame_counter_q <= frame_counter_q + FRAME_W'(1);
			ref_sel_q <= ref_sel_q ^ changed;
			have_ref_q <= 1'b1;
		end else if (valid_s2) begin
			changed_count_q <= count_sum;
		end
	end

	a_first_flagged: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && !have_ref_q |-> res.frame_changed)
		else $error("first frame not flagged");

	a_ref_kept: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(have_ref_q))
		else $error("reference lost");

	a_flip_on_flag: assert property (@(posedge clk) disable iff (!arst_n)
		ref_sel_q != $past(ref_sel_q) |-> $past(res_push && res.frame_changed))
		else $error("reference bank flipped without flagged frame");
endmodule

// ===== src/fcd_out_buf.sv =====
module fcd_out_buf import fcd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  result_t            din,
	fcd_result_if.source       result,
	output logic [LEVEL_W-1:0] level
);
	result_t            fifo_q [OUT_DEPTH];
	logic [PTR_W-1:0]   head_q;
	logic [PTR_W-1:0]   tail_q;
	logic [LEVEL_W-1:0] level_q;
	logic               pop;
	result_t            head_item;

	assign level = level_q;
	assign result.valid = (level_q != '0);
	assign pop = result.valid && result.ready;
	assign head_item = fifo_q[head_q];
	assign result.frame_changed = head_item.frame_changed;
	assign result.changed_pixels = head_item.changed_pixels;
	assign result.frame_index = head_item.frame_index;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[tail_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			level_q <= '0;
		end else begin
			if (push) begin
				tail_q <= tail_q + PTR_W'(1);
			end
			if (pop) begin
				head_q <= head_q + PTR_W'(1);
			end
			level_q <= level_q + LEVEL_W'(push) - LEVEL_W'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && level_q == LEVEL_W'(OUT_DEPTH) |-> pop)
		else $error("result buffer overflow");
endmodule

// ===== src/frame_change_detector.sv =====
// channel  | dir | transaction
// pixel    | in  | one bgr pixel of the region, raster order
// result   | out | one frame verdict at the last pixel of a frame
// apb      | in  | register writes and reads, pready always high
//
// one pixel per cycle while pixel ready is high; a pixel passes stages 1 and 2 to its verdict
// gray buffers sit in two rams, both read every cycle and one written in stage 2
// forwarding covers reads of an entry that the two stages ahead still write
// a four-entry result buffer parts the output; pixel ready drops only when it could fill
// reset clears counters and flags; the gray buffers are not cleared
module frame_change_detector import fcd_pkg::*; #(
	parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	fcd_pixel_if.sink         pixel,
	fcd_result_if.source      result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);
	cfg_t               cfg;
	logic               res_push;
	result_t            res;
	logic [LEVEL_W-1:0] out_level;

	fcd_cfg #(
		.MAX_PIXELS(MAX_PIXELS)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	fcd_pipe #(
		.MAX_PIXELS(MAX_PIXELS)
	) u_pipe (
		.clk      (clk),
		.arst_n   (arst_n),
		.pixel    (pixel),
		.cfg      (cfg),
		.out_level(out_level),
		.res_push (res_push),
		.res      (res)
	);

	fcd_out_buf u_out_buf (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.din   (res),
		.result(result),
		.level (out_level)
	);
endmodule
